FILE: src/ices_pkg.sv
// ----------------------------------------------------------------------------
// ices_pkg
// Shared types, constants and tables for the icon change symbol encoder.
// ----------------------------------------------------------------------------
package ices_pkg;

  localparam int NUM_ICONS         = 40;
  localparam int VOLUME_BARS       = 11;
  localparam int VOLUME_START_CODE = 2;
  localparam int VOL_W             = 4;
  localparam int VOL_DIV           = 10;
  localparam int WORD_W            = 44;
  localparam int CODE_W            = 8;

  localparam int ICON_IDX_W = (NUM_ICONS > 1) ? $clog2(NUM_ICONS) : 1;
  localparam int BAR_IDX_W  = (VOLUME_BARS > 1) ? $clog2(VOLUME_BARS) : 1;
  localparam int LIMIT_W    = 5;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef code_t  icon_tbl_t [40];
  typedef limit_t bar_tbl_t  [2**VOL_W];

  localparam icon_tbl_t ICON_CODES = '{
    8'h01, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22,
    8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d,
    8'h2e, 8'h2f, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37
  };

  // highest lit bar index per volume level, built at elaboration
  function automatic bar_tbl_t build_bar_tbl();
    bar_tbl_t t;
    for (int v = 0; v < 2**VOL_W; v++) begin
      t[v] = LIMIT_W'((v * VOLUME_BARS) / VOL_DIV);
    end
    return t;
  endfunction

  localparam bar_tbl_t BAR_LIMIT = build_bar_tbl();

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ICON,
    ST_BAR
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_icon;
    logic emit_bar;
  } ices_cmd_t;

  typedef struct packed {
    logic in_icon_chg;
    logic in_vol_chg;
    logic icon_more;
    logic vol_chg;
    logic bar_end;
    logic slot_free;
  } ices_sts_t;

endpackage

FILE: src/ices_ctrl.sv
// ----------------------------------------------------------------------------
// ices_ctrl
// Sequencer: walks changed icons, then the volume bar report.
// ----------------------------------------------------------------------------
module ices_ctrl
  import ices_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ices_sts_t sts,
  output ices_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_icon_chg) begin
            state_nxt = ST_ICON;
          end else if (sts.in_vol_chg) begin
            state_nxt = ST_BAR;
          end
        end
      end
      ST_ICON: begin
        if (sts.slot_free) begin
          cmd.emit_icon = 1'b1;
          if (!sts.icon_more) begin
            state_nxt = sts.vol_chg ? ST_BAR : ST_IDLE;
          end
        end
      end
      ST_BAR: begin
        if (sts.slot_free) begin
          cmd.emit_bar = 1'b1;
          if (sts.bar_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/ices_dp.sv
// ----------------------------------------------------------------------------
// ices_dp
// Datapath: previous word, changed-icon mask, bar counter, output register.
// ----------------------------------------------------------------------------
module ices_dp
  import ices_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] in_icon_word,
  input  ices_cmd_t         cmd,
  output ices_sts_t         sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_symbol_code,
  output logic              out_lit,
  output logic              out_volume_group,
  output logic              out_last
);

  logic [WORD_W-1:0]    prev_r;
  logic [NUM_ICONS-1:0] mask_r, mask_nxt;
  logic                 vol_chg_r;
  logic [BAR_IDX_W-1:0] bar_idx_r;

  logic       out_valid_r;
  code_t      out_code_r;
  logic       out_lit_r, out_grp_r, out_last_r;

  logic [NUM_ICONS-1:0]  in_chg;
  logic [VOL_W-1:0]      vol_cur, vol_in;
  logic [ICON_IDX_W-1:0] sel_idx;
  logic [NUM_ICONS-1:0]  icon_state;
  logic                  bar_lit;
  code_t                 bar_code;

  assign in_chg     = in_icon_word[NUM_ICONS-1:0] ^ prev_r[NUM_ICONS-1:0];
  assign vol_in     = in_icon_word[NUM_ICONS +: VOL_W];
  assign vol_cur    = prev_r[NUM_ICONS +: VOL_W];
  assign icon_state = prev_r[NUM_ICONS-1:0];

  // lowest pending icon
  always_comb begin
    sel_idx = '0;
    for (int i = NUM_ICONS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel_idx = ICON_IDX_W'(i);
      end
    end
  end

  always_comb begin
    mask_nxt          = mask_r;
    mask_nxt[sel_idx] = 1'b0;
  end

  assign bar_lit  = (vol_cur != '0) &&
                    (LIMIT_W'(bar_idx_r) <= BAR_LIMIT[vol_cur]);
  assign bar_code = CODE_W'(VOLUME_START_CODE) + CODE_W'(bar_idx_r);

  always_comb begin
    sts.in_icon_chg = |in_chg;
    sts.in_vol_chg  = (vol_in != vol_cur);
    sts.icon_more   = |mask_nxt;
    sts.vol_chg     = vol_chg_r;
    sts.bar_end     = (bar_idx_r == BAR_IDX_W'(VOLUME_BARS - 1));
    sts.slot_free   = !out_valid_r || out_ready;
  end

  // after a load prev_r already holds the new word, so it gives icon states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.load) begin
      prev_r <= in_icon_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r    <= in_chg;
      vol_chg_r <= (vol_in != vol_cur);
      bar_idx_r <= '0;
    end else begin
      if (cmd.emit_icon) begin
        mask_r <= mask_nxt;
      end
      if (cmd.emit_bar) begin
        bar_idx_r <= bar_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_icon || cmd.emit_bar) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_icon) begin
      out_code_r <= ICON_CODES[sel_idx];
      out_lit_r  <= icon_state[sel_idx];
      out_grp_r  <= 1'b0;
      out_last_r <= !(|mask_nxt) && !vol_chg_r;
    end else if (cmd.emit_bar) begin
      out_code_r <= bar_code;
      out_lit_r  <= bar_lit;
      out_grp_r  <= 1'b1;
      out_last_r <= sts.bar_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_code  = out_code_r;
  assign out_lit          = out_lit_r;
  assign out_volume_group = out_grp_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_icon && cmd.emit_bar))
    else $error("icon and bar beat issued together");

  a_icon_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_icon |-> (mask_r != '0))
    else $error("icon beat with empty change mask");

  a_quiet_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !sts.in_icon_chg && !sts.in_vol_chg)
      |=> !(cmd.emit_icon || cmd.emit_bar))
    else $error("beat emitted for unchanged word");

  a_bar_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_bar && sts.bar_end) |=> !cmd.emit_bar)
    else $error("bar report ran past its end");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.emit_icon || cmd.emit_bar))
    else $error("beat overwrote a pending result");
`endif

endmodule

FILE: src/icon_change_symbol_encoder_unit.sv
// ----------------------------------------------------------------------------
// icon_change_symbol_encoder_unit
// Turns icon word updates into display symbol set/clear beats.
// ----------------------------------------------------------------------------
// Each accepted word is compared with the previous one. Every changed icon
// bit, lowest first, yields one beat (symbol code, new state); a changed
// volume field then yields the full bar report. The last beat of a word
// carries out_last; a word with no change yields nothing. One item is
// processed at a time: after the word is accepted, the sequencer emits
// one result beat per cycle into the output register while the output
// slot is free (changed icons, then 11 bars if the volume changed);
// an output stall holds the sequencer until the slot frees.
module icon_change_symbol_encoder_unit
  import ices_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_icon_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_symbol_code,
  output logic              out_lit,
  output logic              out_volume_group,
  output logic              out_last
);

  ices_cmd_t cmd;
  ices_sts_t sts;

  ices_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ices_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_icon_word     (in_icon_word),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol_code  (out_symbol_code),
    .out_lit          (out_lit),
    .out_volume_group (out_volume_group),
    .out_last         (out_last)
  );

endmodule
